### rtl/scca_pkg.sv
package scca_pkg;

   localparam int OP_W = 2;
   localparam int SUBPIX_W = 14;
   localparam int INDEX_W = 10;
   localparam int COV_W = 8;

   localparam int SUB_SHIFT = 3;
   localparam int PIX_W = SUBPIX_W - SUB_SHIFT;

   localparam logic [SUB_SHIFT:0] SUB_FULL = 4'd8;

   localparam logic [OP_W-1:0] OP_ADD_SPAN = 2'd0;
   localparam logic [OP_W-1:0] OP_READ = 2'd1;
   localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      CMD_RESP,
      CMD_ADD,
      CMD_READ,
      CMD_READ_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [PIX_W-1:0] first;
      logic [PIX_W-1:0] last;
      logic [PIX_W-1:0] stop;
      logic [SUB_SHIFT-1:0] b_lo;
      logic [SUB_SHIFT:0] e_hi;
      logic bad;
   } cmd_type;

   typedef struct packed {
      logic init_done;
   } back_status_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_WRITE,
      B_DONE
   } back_state_type;

endpackage

### rtl/scca_req_if.sv
interface scca_req_if import scca_pkg::*; ();
   logic valid;
   logic ready;
   logic [OP_W-1:0] opcode;
   logic [SUBPIX_W-1:0] span_begin;
   logic [SUBPIX_W-1:0] span_end;
   logic [INDEX_W-1:0] pixel_index;

   modport source (output valid, output opcode, output span_begin, output span_end,
                   output pixel_index, input ready);
   modport sink (input valid, input opcode, input span_begin, input span_end,
                 input pixel_index, output ready);
endinterface

### rtl/scca_rsp_if.sv
interface scca_rsp_if import scca_pkg::*; ();
   logic valid;
   logic ready;
   logic [COV_W-1:0] pixel_coverage;
   logic bad_span;

   modport source (output valid, output pixel_coverage, output bad_span, input ready);
   modport sink (input valid, input pixel_coverage, input bad_span, output ready);
endinterface

### rtl/scca_front.sv
module scca_front import scca_pkg::*; #(
   parameter int LINE_PIXELS = 1024
) (
   scca_req_if.sink req_ch,
   input back_status_type status,
   input logic q_full,
   output logic push_valid,
   output cmd_type push_cmd
);

   localparam int CNT_W = $clog2(LINE_PIXELS + 1);
   localparam int CMP_W = (CNT_W > PIX_W) ? CNT_W : PIX_W;
   localparam logic [CMP_W-1:0] LIMIT = CMP_W'(LINE_PIXELS);

   logic [SUBPIX_W-1:0] end_m1;
   logic [PIX_W-1:0] first_pix;
   logic [PIX_W-1:0] last_pix;
   logic [PIX_W-1:0] read_pix;
   logic first_in_row;
   logic last_in_row;
   logic read_in_row;

   assign req_ch.ready = status.init_done && !q_full;
   assign push_valid = req_ch.valid && req_ch.ready;

   assign end_m1 = req_ch.span_end - 14'd1;
   assign first_pix = req_ch.span_begin[SUBPIX_W-1:SUB_SHIFT];
   assign last_pix = end_m1[SUBPIX_W-1:SUB_SHIFT];
   assign read_pix = PIX_W'(req_ch.pixel_index);
   assign first_in_row = CMP_W'(first_pix) < LIMIT;
   assign last_in_row = CMP_W'(last_pix) < LIMIT;
   assign read_in_row = CMP_W'(read_pix) < LIMIT;

   always_comb begin
      push_cmd.kind = CMD_RESP;
      push_cmd.first = first_pix;
      push_cmd.last = last_pix;
      push_cmd.stop = last_in_row ? last_pix : PIX_W'(LINE_PIXELS - 1);
      push_cmd.b_lo = req_ch.span_begin[SUB_SHIFT-1:0];
      push_cmd.e_hi = {1'b0, end_m1[SUB_SHIFT-1:0]} + 4'd1;
      push_cmd.bad = 1'b0;
      unique case (req_ch.opcode)
         OP_ADD_SPAN: begin
            if (req_ch.span_begin > req_ch.span_end) begin
               push_cmd.bad = 1'b1;
            end else if (req_ch.span_begin != req_ch.span_end && first_in_row) begin
               push_cmd.kind = CMD_ADD;
            end
         end
         OP_READ: begin
            push_cmd.first = read_pix;
            if (read_in_row) begin
               push_cmd.kind = CMD_READ;
            end
         end
         OP_READ_CLEAR: begin
            push_cmd.first = read_pix;
            if (read_in_row) begin
               push_cmd.kind = CMD_READ_CLEAR;
            end
         end
         default: begin
            push_cmd.kind = CMD_RESP;
         end
      endcase
   end

endmodule

### rtl/scca_queue.sv
module scca_queue import scca_pkg::*; (
   input logic clock,
   input logic reset,
   input logic push_valid,
   input cmd_type push_cmd,
   output logic q_full,
   output logic q_valid,
   output cmd_type q_cmd,
   input logic q_pop
);

   cmd_type entry_ff [2];
   logic wr_ptr_ff;
   logic wr_ptr_in;
   logic rd_ptr_ff;
   logic rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic do_push;
   logic do_pop;

   assign q_full = count_ff == 2'd2;
   assign q_valid = count_ff != 2'd0;
   assign q_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && !q_full;
   assign do_pop = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != 2'd0)
      else $error("pop from empty queue");

endmodule

### rtl/scca_back.sv
module scca_back import scca_pkg::*; #(
   parameter int LINE_PIXELS = 1024
) (
   input logic clock,
   input logic reset,
   input logic q_valid,
   input cmd_type q_cmd,
   output logic q_pop,
   output back_status_type status,
   scca_rsp_if.source rsp_ch
);

   localparam int ADDR_W = $clog2(LINE_PIXELS);
   localparam int CNT_W = $clog2(LINE_PIXELS + 1);
   localparam int CMP_W = (CNT_W > PIX_W) ? CNT_W : PIX_W;
   localparam logic [CMP_W-1:0] LIMIT = CMP_W'(LINE_PIXELS);
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(LINE_PIXELS - 1);

   back_state_type state_ff;
   back_state_type state_in;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic [PIX_W-1:0] cur_ff;
   logic [PIX_W-1:0] cur_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;
   logic [COV_W-1:0] cov_res_ff;
   logic [COV_W-1:0] cov_res_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic [COV_W-1:0] rsp_cov_ff;
   logic [COV_W-1:0] rsp_cov_in;
   logic rsp_bad_ff;
   logic rsp_bad_in;

   logic [COV_W-1:0] row_mem [LINE_PIXELS];
   logic [COV_W-1:0] rd_ff;
   logic rd_en;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [COV_W-1:0] wr_data;

   logic out_free;
   logic [SUB_SHIFT:0] sub_lo;
   logic [SUB_SHIFT:0] sub_hi;
   logic [SUB_SHIFT:0] sub_add;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign status.init_done = state_ff != B_CLEAR;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.pixel_coverage = rsp_cov_ff;
   assign rsp_ch.bad_span = rsp_bad_ff;

   // Subpixels of the current pixel that fall inside the span.
   assign sub_lo = (cur_ff == cmd_ff.first) ? {1'b0, cmd_ff.b_lo} : '0;
   assign sub_hi = (cur_ff == cmd_ff.last) ? cmd_ff.e_hi : SUB_FULL;
   assign sub_add = sub_hi - sub_lo;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_CLEAR: begin
            if (clr_addr_ff == CLR_LAST) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (q_valid) begin
               state_in = (q_cmd.kind == CMD_RESP) ? B_DONE : B_READ;
            end
         end
         B_READ: begin
            state_in = B_WRITE;
         end
         B_WRITE: begin
            if (cmd_ff.kind != CMD_ADD || cur_ff == cmd_ff.stop) begin
               state_in = B_DONE;
            end else begin
               state_in = B_READ;
            end
         end
         B_DONE: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop = 1'b0;
      cmd_in = cmd_ff;
      cur_in = cur_ff;
      clr_addr_in = clr_addr_ff;
      cov_res_in = cov_res_ff;
      rd_en = 1'b0;
      wr_en = 1'b0;
      wr_addr = ADDR_W'(cur_ff);
      wr_data = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_cov_in = rsp_cov_ff;
      rsp_bad_in = rsp_bad_ff;
      unique case (state_ff)
         B_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         B_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               cmd_in = q_cmd;
               cur_in = q_cmd.first;
               cov_res_in = '0;
            end
         end
         B_READ: begin
            rd_en = 1'b1;
         end
         B_WRITE: begin
            if (cmd_ff.kind == CMD_ADD) begin
               wr_en = 1'b1;
               wr_data = rd_ff + COV_W'(sub_add);
               if (cur_ff != cmd_ff.stop) begin
                  cur_in = cur_ff + 1'b1;
               end
            end else begin
               cov_res_in = rd_ff;
               wr_en = cmd_ff.kind == CMD_READ_CLEAR;
            end
         end
         B_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cov_in = cov_res_ff;
               rsp_bad_in = cmd_ff.bad;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      cur_ff <= cur_in;
      cov_res_ff <= cov_res_in;
      rsp_cov_ff <= rsp_cov_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= row_mem[ADDR_W'(cur_ff)];
      end
   end

   a_pixel_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_WRITE && cmd_ff.kind == CMD_ADD)
         |-> (cur_ff >= cmd_ff.first && cur_ff <= cmd_ff.stop))
      else $error("pixel walk left the span");

   a_pixel_in_row: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_READ |-> CMP_W'(cur_ff) < LIMIT)
      else $error("memory access beyond the row");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DONE && !out_free) |=> (state_ff == B_DONE && $stable(cov_res_ff)))
      else $error("pending result lost while output stalled");

endmodule

### rtl/span_coverage_accumulate_unit.sv
// Scanline coverage accumulator with eight subpixels per pixel.
// The request channel carries one beat per item: add a half-open subpixel span to
// the row, read one pixel's coverage byte, or read it and then clear it.
// The response channel returns exactly one beat per request, in request order:
// the coverage byte for reads (zero otherwise) and a flag for reversed spans.
// Requests enter a two-entry queue; a sequencer behind it performs one
// read-modify-write of the row memory per pixel, on a single-port memory of
// LINE_PIXELS bytes.
// Each response is registered: the sequencer loads it into the output register
// when it finishes a request.
// After reset the row is zeroed by a sweep, one byte per cycle, during which no
// request beat is taken.
// When the receiver stalls, one response waits in the output register, the
// sequencer holds the next finished result, and the queue keeps taking requests
// until it is full.
module span_coverage_accumulate_unit import scca_pkg::*; #(
   parameter int LINE_PIXELS = 1024
) (
   input logic clock,
   input logic reset,
   scca_req_if.sink req_ch,
   scca_rsp_if.source rsp_ch
);

   back_status_type status;
   logic q_full;
   logic push_valid;
   cmd_type push_cmd;
   logic q_valid;
   cmd_type q_cmd;
   logic q_pop;

   scca_front #(
      .LINE_PIXELS(LINE_PIXELS)
   ) u_front (
      .req_ch(req_ch),
      .status(status),
      .q_full(q_full),
      .push_valid(push_valid),
      .push_cmd(push_cmd)
   );

   scca_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_cmd(push_cmd),
      .q_full(q_full),
      .q_valid(q_valid),
      .q_cmd(q_cmd),
      .q_pop(q_pop)
   );

   scca_back #(
      .LINE_PIXELS(LINE_PIXELS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_cmd(q_cmd),
      .q_pop(q_pop),
      .status(status),
      .rsp_ch(rsp_ch)
   );

endmodule

### tb/sv/scca_coverage_checker.sv
module scca_coverage_checker import scca_pkg::*; #(
   parameter int LINE_PIXELS = 1024
) (
   input logic clock,
   input logic reset,
   scca_req_if req_ch,
   scca_rsp_if rsp_ch,
   output int fail_count,
   output int pending_count
);

   typedef struct packed {
      logic [COV_W-1:0] coverage;
      logic bad;
   } coverage_rsp_type;

   logic [COV_W-1:0] coverage_shadow [LINE_PIXELS];
   coverage_rsp_type expected_rsp_q [$];

   function automatic void add_span_coverage(int unsigned span_lo, int unsigned span_hi);
      int unsigned first_pix;
      int unsigned last_pix;
      int unsigned pix;
      int unsigned pix_lo;
      int unsigned pix_hi;
      int unsigned cov_lo;
      int unsigned cov_hi;
      first_pix = span_lo >> SUB_SHIFT;
      last_pix = (span_hi - 1) >> SUB_SHIFT;
      for (pix = first_pix; pix <= last_pix && pix < LINE_PIXELS; pix++) begin
         pix_lo = pix << SUB_SHIFT;
         pix_hi = pix_lo + 32'(SUB_FULL);
         cov_lo = (span_lo > pix_lo) ? span_lo : pix_lo;
         cov_hi = (span_hi < pix_hi) ? span_hi : pix_hi;
         coverage_shadow[pix] = coverage_shadow[pix] + COV_W'(cov_hi - cov_lo);
      end
   endfunction

   function automatic coverage_rsp_type predict_coverage(
      logic [OP_W-1:0] op,
      logic [SUBPIX_W-1:0] span_lo,
      logic [SUBPIX_W-1:0] span_hi,
      logic [INDEX_W-1:0] pix_index
   );
      coverage_rsp_type rsp;
      rsp = '0;
      case (op) inside
         OP_ADD_SPAN: begin
            if (span_lo > span_hi) begin
               rsp.bad = 1'b1;
            end else if (span_lo < span_hi) begin
               add_span_coverage(32'(span_lo), 32'(span_hi));
            end
         end
         OP_READ, OP_READ_CLEAR: begin
            if (int'(pix_index) < LINE_PIXELS) begin
               rsp.coverage = coverage_shadow[pix_index];
               if (op == OP_READ_CLEAR) begin
                  coverage_shadow[pix_index] = '0;
               end
            end
         end
         default: begin
         end
      endcase
      return rsp;
   endfunction

   always @(posedge clock) begin
      coverage_rsp_type want;
      int errs;
      int pix;
      errs = 0;
      if (reset) begin
         for (pix = 0; pix < LINE_PIXELS; pix++) begin
            coverage_shadow[pix] = '0;
         end
         expected_rsp_q.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_rsp_q.push_back(predict_coverage(req_ch.opcode, req_ch.span_begin,
                                                      req_ch.span_end, req_ch.pixel_index));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response beat with no request outstanding");
               errs++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_ch.pixel_coverage !== want.coverage) begin
                  $error("pixel_coverage expected %0d actual %0d",
                         want.coverage, rsp_ch.pixel_coverage);
                  errs++;
               end
               if (rsp_ch.bad_span !== want.bad) begin
                  $error("bad_span expected %0d actual %0d", want.bad, rsp_ch.bad_span);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending_count <= expected_rsp_q.size();
      end
   end

endmodule

### tb/sv/tb_span_coverage_accumulate_unit.sv
module tb_span_coverage_accumulate_unit;
   import scca_pkg::*;

   localparam int LINE_PIXELS = 1024;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 450;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_BEAT = 30;
   localparam int SUBPIX_MAX = (1 << SUBPIX_W) - 1;

   logic clock;
   logic reset;
   int fail_count;
   int pending_count;
   int req_gap_max;
   int rsp_gap_max;

   scca_req_if req_ch();
   scca_rsp_if rsp_ch();

   span_coverage_accumulate_unit #(.LINE_PIXELS(LINE_PIXELS)) i_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   scca_coverage_checker #(.LINE_PIXELS(LINE_PIXELS)) i_checker (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_item(input logic [OP_W-1:0] op, input int span_lo, input int span_hi,
                            input int pix_index);
      int gap;
      gap = $urandom_range(req_gap_max, 0);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.span_begin <= SUBPIX_W'(span_lo);
      req_ch.span_end <= SUBPIX_W'(span_hi);
      req_ch.pixel_index <= INDEX_W'(pix_index);
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   function automatic int pick_gap_max();
      int pick;
      pick = $urandom_range(0, 2);
      return (pick == 0) ? 0 : ((pick == 1) ? 2 : 6);
   endfunction

   // The receiver holds off once for a long stretch so that the request queue fills.
   initial begin
      int gap;
      int rsp_beats;
      rsp_beats = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         gap = (rsp_beats == HOLD_OFF_BEAT) ? HOLD_OFF_CYCLES : $urandom_range(rsp_gap_max, 0);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         rsp_beats++;
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("FAIL span_coverage_accumulate_unit");
      $finish;
   end

   initial begin
      int i;
      int pick;
      int variant;
      int window_base;
      int base_pix;
      int span_lo;
      int span_hi;
      int pix_index;
      logic [OP_W-1:0] op;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_ADD_SPAN;
      req_ch.span_begin = '0;
      req_ch.span_end = '0;
      req_ch.pixel_index = '0;
      req_gap_max = 6;
      rsp_gap_max = 6;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_READ, 0, 0, 0);
      send_item(OP_ADD_SPAN, 3, SUBPIX_MAX, 0);
      send_item(OP_READ, 0, 0, 0);
      send_item(OP_READ, 0, 0, LINE_PIXELS - 1);
      send_item(OP_ADD_SPAN, 8180, 8200, 1023);
      send_item(OP_READ_CLEAR, 0, 0, LINE_PIXELS - 1);
      send_item(OP_READ, 0, 0, LINE_PIXELS - 1);
      send_item(OP_READ, 0, 0, LINE_PIXELS - 2);
      send_item(OP_ADD_SPAN, 8192, 8200, 0);
      send_item(OP_ADD_SPAN, SUBPIX_MAX, 0, 0);
      send_item(OP_ADD_SPAN, 9, 8, 0);
      send_item(OP_ADD_SPAN, 100, 100, 0);
      send_item(OP_ADD_SPAN, 0, 0, 0);
      send_item(OP_ADD_SPAN, SUBPIX_MAX, SUBPIX_MAX, 1023);
      send_item(OP_ADD_SPAN, 17, 21, 0);
      send_item(OP_READ_CLEAR, 0, 0, 2);
      send_item(OP_READ, 0, 0, 2);
      send_item(OP_UNUSED, SUBPIX_MAX, SUBPIX_MAX, 1023);
      send_item(OP_UNUSED, 0, 0, 0);
      send_item(OP_ADD_SPAN, 0, 8192, 0);
      send_item(OP_READ_CLEAR, SUBPIX_MAX, 'h2AAA, 0);
      send_item(OP_READ, 0, 0, 1);
      send_item(OP_READ_CLEAR, 0, 0, 512);

      window_base = $urandom_range(0, LINE_PIXELS - 8);
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 75 == 0) begin
            req_gap_max = (i == 75) ? 0 : pick_gap_max();
            rsp_gap_max = (i == 75) ? 0 : pick_gap_max();
         end
         pick = $urandom_range(0, 99);
         variant = $urandom_range(0, 99);
         base_pix = window_base + $urandom_range(0, 7);
         span_lo = $urandom_range(0, SUBPIX_MAX);
         span_hi = $urandom_range(0, SUBPIX_MAX);
         pix_index = $urandom_range(0, (1 << INDEX_W) - 1);
         if (pick < 55) begin
            op = OP_ADD_SPAN;
            if (variant < 20) begin
               span_hi = span_lo + $urandom_range(0, 24);
            end else if (variant >= 22) begin
               span_lo = base_pix * 8 + $urandom_range(0, 7);
               if (variant < 30) begin
                  span_hi = span_lo - $urandom_range(1, 20);
                  if (span_hi < 0) begin
                     span_hi = 0;
                     span_lo = span_lo + 1;
                  end
               end else if (variant < 36) begin
                  span_hi = span_lo;
               end else begin
                  span_hi = span_lo + $urandom_range(1, 40);
               end
            end
            if (span_hi > SUBPIX_MAX) begin
               span_hi = SUBPIX_MAX;
            end
         end else if (pick < 75) begin
            op = OP_READ;
            if (variant >= 20) begin
               pix_index = base_pix;
            end
         end else if (pick < 87) begin
            op = OP_READ_CLEAR;
            if (variant >= 20) begin
               pix_index = base_pix;
            end
         end else if (pick < 92) begin
            op = OP_UNUSED;
         end else begin
            op = OP_READ;
         end
         send_item(op, span_lo, span_hi, pix_index);
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS span_coverage_accumulate_unit");
      end else begin
         $display("FAIL span_coverage_accumulate_unit");
      end
      $finish;
   end

endmodule

### sim.f
rtl/scca_pkg.sv
rtl/scca_req_if.sv
rtl/scca_rsp_if.sv
rtl/scca_front.sv
rtl/scca_queue.sv
rtl/scca_back.sv
rtl/span_coverage_accumulate_unit.sv
tb/sv/scca_coverage_checker.sv
tb/sv/tb_span_coverage_accumulate_unit.sv
